/* sv/mean_3x3_stencil_sweep_defines.svh */
// ----------------------------------------------------------------------------
// mean_3x3_stencil_sweep_defines.svh
// Assertion macros shared by the stencil sweep RTL.
// ----------------------------------------------------------------------------
`ifndef MEAN_3X3_STENCIL_SWEEP_DEFINES_SVH
`define MEAN_3X3_STENCIL_SWEEP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MEAN3_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MEAN3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mean3_pkg.sv */
// ----------------------------------------------------------------------------
// mean3_pkg
// Types and constants of the 3x3 mean stencil sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mean3_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GRID_W     = 11;
	localparam int GRID_RST   = 64;
	localparam int SUM_W      = SAMPLE_W + 4;
	localparam int MULT_W     = 20;
	localparam int PROD_W     = SUM_W + MULT_W;
	localparam int DIV9_SHIFT = 23;
	// ceil(2^23 / 9), exact for every sum below 2^21
	localparam logic [MULT_W-1:0] DIV9_MULT = 20'd932068;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_DRAIN  = 1'b1
	} action_t;

	// neighbor row/column lies inside the grid
	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} nb_mask_t;

endpackage

/* sv/mean3_linebuf.sv */
// ----------------------------------------------------------------------------
// mean3_linebuf
// Two row delay lines: current row feeds the row above, one column a cycle while enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mean_3x3_stencil_sweep_defines.svh"

module mean3_linebuf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  mean3_pkg::sample_t wr_data,
	output mean3_pkg::sample_t rd_above,
	output mean3_pkg::sample_t rd_cur
);

	mean3_pkg::sample_t mem_above [DEPTH];
	mean3_pkg::sample_t mem_cur   [DEPTH];
	mean3_pkg::sample_t rd_above_q;
	mean3_pkg::sample_t rd_cur_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_above_q <= mem_above[rd_addr];
			rd_cur_q   <= mem_cur[rd_addr];
		end
		if (wr_en) begin
			mem_above[wr_addr] <= rd_cur_q;
			mem_cur[wr_addr]   <= wr_data;
		end
	end

	assign rd_above = rd_above_q;
	assign rd_cur   = rd_cur_q;

	// column 0 is reread at a frame restart while the last drain writes it; rows above are masked
	`MEAN3_ASSERT(a_no_rw_collision, wr_en && rd_en && (rd_addr != '0), wr_addr != rd_addr, "line store read and write hit one column")

endmodule

/* sv/mean3_kernel.sv */
// ----------------------------------------------------------------------------
// mean3_kernel
// 3x3 window registers and the neighborhood sum, out-of-grid taps replaced by the center.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mean3_kernel (
	input  logic                           clk,
	input  logic                           shift,
	input  mean3_pkg::sample_t             col_top,
	input  mean3_pkg::sample_t             col_mid,
	input  mean3_pkg::sample_t             col_bot,
	input  mean3_pkg::nb_mask_t            mask,
	output logic [mean3_pkg::SUM_W-1:0]    sum
);

	mean3_pkg::sample_t win_q [3][3];
	mean3_pkg::sample_t col_in [3];
	logic [2:0] row_ok;
	logic [2:0] col_ok;

	assign col_in[0] = col_top;
	assign col_in[1] = col_mid;
	assign col_in[2] = col_bot;
	assign row_ok = {mask.bot_ok, 1'b1, mask.top_ok};
	assign col_ok = {mask.right_ok, 1'b1, mask.left_ok};

	always_ff @(posedge clk) begin
		if (shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
				win_q[r][2] <= col_in[r];
			end
		end
	end

	// neighborhood columns: win col 1, win col 2 (center), incoming column
	always_comb begin
		logic [mean3_pkg::SUM_W-1:0] acc;
		mean3_pkg::sample_t          tap;
		acc = mean3_pkg::SUM_W'(4);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!(row_ok[r] && col_ok[c])) begin
					tap = win_q[1][2];
				end else if (c == 2) begin
					tap = col_in[r];
				end else begin
					tap = win_q[r][c+1];
				end
				acc = acc + mean3_pkg::SUM_W'(tap);
			end
		end
		sum = acc;
	end

endmodule

/* sv/mean3_div9.sv */
// ----------------------------------------------------------------------------
// mean3_div9
// Divide the rounded neighborhood sum by nine with a reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mean3_div9 (
	input  logic [mean3_pkg::SUM_W-1:0] sum,
	output mean3_pkg::sample_t          quo
);

	logic [mean3_pkg::PROD_W-1:0] prod;

	assign prod = mean3_pkg::PROD_W'(sum) * mean3_pkg::PROD_W'(mean3_pkg::DIV9_MULT);
	assign quo  = prod[mean3_pkg::DIV9_SHIFT +: mean3_pkg::SAMPLE_W];

endmodule

/* sv/mean_3x3_stencil_sweep.sv */
// ----------------------------------------------------------------------------
// mean_3x3_stencil_sweep
// Pipeline: a result passes the stage 1, stage 2 and stage 3 registers after the
// transaction that causes it. Throughput: one transaction per cycle unless m_tready
// stalls the output, set by the one-read/one-write line store column per cycle and
// the window shift. Reset: counters and valids clear, grid size returns to 64
// (MAX_SIZE if smaller); line store and window contents are left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mean_3x3_stencil_sweep_defines.svh"

module mean_3x3_stencil_sweep #(
	parameter int MAX_SIZE = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          grid_size_we,
	input  logic [mean3_pkg::GRID_W-1:0]  grid_size,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] sample
	input  logic [0:0]                    s_tuser,   // [0] action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [15:0] mean_value
	output logic                          m_tlast
);

	localparam int AW = $clog2(MAX_SIZE);
	localparam int NW = $clog2(MAX_SIZE + 1);
	localparam int CW = (NW > mean3_pkg::GRID_W) ? NW : mean3_pkg::GRID_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_SIZE);
	localparam logic [CW-1:0] MIN_C = CW'(2);
	localparam logic [NW-1:0] N_RST = (mean3_pkg::GRID_RST > MAX_SIZE) ?
		NW'(MAX_SIZE) : NW'(mean3_pkg::GRID_RST);

	typedef struct packed {
		logic                emit;
		logic                frame_end;
		mean3_pkg::nb_mask_t mask;
	} s1_ctrl_t;

	logic [NW-1:0] n_q;
	logic [AW-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
	logic          full_q;

	logic [CW-1:0] g_ext, n_new;
	logic [NW-1:0] n_m1;
	logic          is_drain, acc, tick, emit, frame_end;
	logic          in_col_last, in_row_last, out_col_last, out_row_last;
	logic [AW-1:0] col_nxt;
	s1_ctrl_t      ctrl_in;

	logic                         valid_s1, valid_s2, valid_s3;
	s1_ctrl_t                     ctrl_s1;
	mean3_pkg::sample_t           bot_s1;
	logic [AW-1:0]                addr_s1;
	logic [mean3_pkg::SUM_W-1:0]  sum_s2;
	logic                         fe_s2;
	mean3_pkg::sample_t           mean_s3;
	logic                         last_s3;
	logic                         en1, en2, en3, shift;

	mean3_pkg::sample_t           rd_above, rd_cur, quo;
	logic [mean3_pkg::SUM_W-1:0]  sum;

	// grid size clamp
	assign g_ext = CW'(grid_size);
	assign n_new = (g_ext < MIN_C) ? MIN_C : ((g_ext > MAX_C) ? MAX_C : g_ext);
	assign n_m1  = n_q - NW'(1);

	assign is_drain     = (mean3_pkg::action_t'(s_tuser[0]) == mean3_pkg::ACT_DRAIN);
	assign acc          = s_tvalid && s_tready;
	assign in_col_last  = (NW'(in_col_q) == n_m1);
	assign in_row_last  = (NW'(in_row_q) == n_m1);
	assign out_col_last = (NW'(out_col_q) == n_m1);
	assign out_row_last = (NW'(out_row_q) == n_m1);
	assign col_nxt      = in_col_last ? '0 : in_col_q + AW'(1);

	assign tick      = is_drain ? full_q : !full_q;
	assign emit      = is_drain ? full_q :
		((in_row_q > AW'(1)) || ((in_row_q == AW'(1)) && (in_col_q != '0)));
	assign frame_end = out_row_last && out_col_last;

	assign ctrl_in.emit           = emit;
	assign ctrl_in.frame_end      = frame_end;
	assign ctrl_in.mask.top_ok    = (out_row_q != '0);
	assign ctrl_in.mask.bot_ok    = !out_row_last;
	assign ctrl_in.mask.left_ok   = (out_col_q != '0);
	assign ctrl_in.mask.right_ok  = !out_col_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= N_RST;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			full_q    <= 1'b0;
		end else if (grid_size_we) begin
			n_q       <= n_new[NW-1:0];
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			full_q    <= 1'b0;
		end else if (acc) begin
			if (emit && frame_end) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
				full_q    <= 1'b0;
			end else begin
				if (tick) begin
					in_col_q <= col_nxt;
				end
				if (tick && !is_drain && in_col_last) begin
					if (in_row_last) begin
						full_q   <= 1'b1;
						in_row_q <= '0;
					end else begin
						in_row_q <= in_row_q + AW'(1);
					end
				end
				if (emit) begin
					out_col_q <= out_col_last ? '0 : out_col_q + AW'(1);
					if (out_col_last) begin
						out_row_q <= out_row_q + AW'(1);
					end
				end
			end
		end
	end

	// pipeline flow control
	assign en3      = !valid_s3 || m_tready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;
	assign shift    = valid_s1 && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= tick;
			end else if (en2) begin
				valid_s1 <= 1'b0;
			end
			if (en2) begin
				valid_s2 <= valid_s1 && ctrl_s1.emit;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctrl_s1 <= ctrl_in;
			bot_s1  <= s_tdata;
			addr_s1 <= in_col_q;
		end
		if (en2) begin
			sum_s2 <= sum;
			fe_s2  <= ctrl_s1.frame_end;
		end
		if (en3) begin
			mean_s3 <= quo;
			last_s3 <= fe_s2;
		end
	end

	mean3_linebuf #(
		.DEPTH (MAX_SIZE),
		.AW    (AW)
	) u_linebuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (acc),
		.rd_addr  (in_col_q),
		.wr_en    (shift),
		.wr_addr  (addr_s1),
		.wr_data  (bot_s1),
		.rd_above (rd_above),
		.rd_cur   (rd_cur)
	);

	mean3_kernel u_kernel (
		.clk     (clk),
		.shift   (shift),
		.col_top (rd_above),
		.col_mid (rd_cur),
		.col_bot (bot_s1),
		.mask    (ctrl_s1.mask),
		.sum     (sum)
	);

	mean3_div9 u_div9 (
		.sum (sum_s2),
		.quo (quo)
	);

	assign m_tvalid = valid_s3;
	assign m_tdata  = mean_s3;
	assign m_tlast  = last_s3;

	`MEAN3_ASSERT(a_out_idle_first_row, !full_q && (in_row_q == '0), (out_row_q == '0) && (out_col_q == '0), "result position ahead of input in first row")
	`MEAN3_ASSERT(a_out_behind_in, !full_q && (in_row_q != '0), out_row_q < in_row_q, "result row not behind input row")
	`MEAN3_ASSERT_NEXT(a_s1_hold, valid_s1 && !en2 && !grid_size_we, valid_s1 && $stable(addr_s1) && $stable(bot_s1), "stalled stage 1 item changed")

endmodule
